// ===== rtl/acfp_pkg.sv =====
// ----------------------------------------------------------------------------
// acfp_pkg
// Shared constants and digit decode for the ASCII CAN frame line parser.
// ----------------------------------------------------------------------------
package acfp_pkg;

  localparam int MAX_DATA_BYTES = 8;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_UPPER_R = 8'h52;  // 'R'
  localparam logic [7:0] CHAR_UPPER_T = 8'h54;  // 'T'
  localparam logic [7:0] CHAR_LOWER_R = 8'h72;  // 'r'

  localparam logic [4:0] DPOS_EXT = 5'd9;
  localparam logic [4:0] DPOS_STD = 5'd4;
  localparam logic [4:0] POS_MAX  = 5'd31;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 104;  // 100 bits of fields, padded to bytes
  localparam int OUT_USER_W = 3;

  // Hex digit decode without validation, wraps mod 256.
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHAR_LOWER_A) begin
      v = c - CHAR_LOWER_A + 8'd10;
    end else if (c >= CHAR_UPPER_A) begin
      v = c - CHAR_UPPER_A + 8'd10;
    end else begin
      v = c - CHAR_ZERO;
    end
    return v;
  endfunction

  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    return {hi[3:0], 4'b0000} | lo;
  endfunction

endpackage

// ===== rtl/ascii_can_frame_parser.sv =====
// ----------------------------------------------------------------------------
// ascii_can_frame_parser
// Receive-side parser for ASCII CAN frame lines, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one character per transfer on in_tdata, with
//   in_tlast marking the final character of a line. A line that starts with
//   R or T is extended (8 id digits), any other start is standard (3 digits);
//   r or R marks a remote frame. On the last character one result leaves on
//   the master side: out_tuser carries the ok/extended/remote flags and
//   out_tdata the identifier, length and payload. A rejected line gives ok
//   low and all other fields zero. Characters without tlast give no result.
//   A result becomes valid once the last character has passed through the
//   input register and been decoded into the result register, unless a
//   stalled result holds it back. Throughput: one character per cycle while
//   no line end waits on a stalled result, set by the single decode stage
//   between the input register and the line state / result register.
//   When the receiver stalls, the result is held; characters that do not end
//   a line keep flowing, and a line end waits in the input register until
//   the result slot frees. Reset clears the line state and both valid flags.
// ----------------------------------------------------------------------------
module ascii_can_frame_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [acfp_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] character
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [acfp_pkg::OUT_DATA_W-1:0] out_tdata,  // [31:0] identifier,
                                                      // [35:32] length,
                                                      // [99:36] payload, zero pad
  output logic [acfp_pkg::OUT_USER_W-1:0] out_tuser   // [0] ok, [1] extended,
                                                      // [2] remote
);
  import acfp_pkg::*;

  // input register
  logic       in_valid_r;
  logic [7:0] char_r;
  logic       last_r;

  // line state
  logic [4:0]  pos_r, pos_nxt;
  logic        ext_r, ext_nxt;
  logic        rem_r, rem_nxt;
  logic [31:0] id_r, id_nxt;
  logic [7:0]  dcount_r, dcount_nxt;
  logic [63:0] data_r, data_nxt;
  logic [7:0]  hi_r, hi_nxt;

  // result register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;

  logic        proc;
  logic        ext_cur, rem_cur;
  logic [7:0]  nib, pair;
  logic [4:0]  dpos, off;
  logic [3:0]  k;
  logic [5:0]  exp_pos;
  logic        ok;
  logic [31:0] id_cur;
  logic [7:0]  dcount_cur;
  logic [63:0] data_cur;

  // a line end may only advance when the result slot is free
  assign proc      = in_valid_r && (!last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc;

  assign nib     = digit_value(char_r);
  assign pair    = pair_value(hi_r, nib);
  assign ext_cur = (pos_r == 5'd0) ? (char_r == CHAR_UPPER_R || char_r == CHAR_UPPER_T)
                                   : ext_r;
  assign rem_cur = (pos_r == 5'd0) ? (char_r == CHAR_LOWER_R || char_r == CHAR_UPPER_R)
                                   : rem_r;
  assign dpos    = ext_cur ? DPOS_EXT : DPOS_STD;
  assign off     = pos_r - dpos - 5'd1;
  assign k       = off[4:1];

  always_comb begin
    id_cur     = id_r;
    dcount_cur = dcount_r;
    data_cur   = data_r;
    hi_nxt     = hi_r;
    if (pos_r > 5'd0 && pos_r < dpos) begin
      if (ext_cur) begin
        if (pos_r[0]) begin
          hi_nxt = nib;
        end else begin
          id_cur = {id_r[23:0], pair};
        end
      end else begin
        priority if (pos_r == 5'd1) begin
          id_cur = {16'b0, nib, 8'b0};
        end else if (pos_r == 5'd2) begin
          hi_nxt = nib;
        end else begin
          id_cur = {16'b0, id_r[15:0] | {8'b0, pair}};
        end
      end
    end else if (pos_r == dpos) begin
      dcount_cur = char_r - CHAR_ZERO;
    end else if (pos_r > dpos) begin
      if (!off[0]) begin
        hi_nxt = nib;
      end else if (k < 4'(MAX_DATA_BYTES)) begin
        data_cur = data_r | ({56'b0, pair} << {k[2:0], 3'b000});
      end
    end
  end

  // final checks use this character's updates
  assign exp_pos = {dcount_cur[4:0], 1'b0} + {1'b0, dpos};

  always_comb begin
    priority if (pos_r < dpos) begin
      ok = 1'b0;
    end else if (dcount_cur > 8'(MAX_DATA_BYTES)) begin
      ok = 1'b0;
    end else if (rem_cur) begin
      ok = (pos_r == dpos);
    end else begin
      ok = ({1'b0, pos_r} == exp_pos);
    end
  end

  always_comb begin
    if (ok) begin
      out_user_nxt = {rem_cur, ext_cur, 1'b1};
      out_data_nxt = {4'b0, (rem_cur ? 64'b0 : data_cur), dcount_cur[3:0], id_cur};
    end else begin
      out_user_nxt = '0;
      out_data_nxt = '0;
    end
  end

  always_comb begin
    if (last_r) begin
      pos_nxt    = '0;
      ext_nxt    = 1'b0;
      rem_nxt    = 1'b0;
      id_nxt     = '0;
      dcount_nxt = '0;
      data_nxt   = '0;
    end else begin
      pos_nxt    = (pos_r < POS_MAX) ? pos_r + 5'd1 : pos_r;
      ext_nxt    = ext_cur;
      rem_nxt    = rem_cur;
      id_nxt     = id_cur;
      dcount_nxt = dcount_cur;
      data_nxt   = data_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      ext_r       <= 1'b0;
      rem_r       <= 1'b0;
      id_r        <= '0;
      dcount_r    <= '0;
      data_r      <= '0;
      hi_r        <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (proc) begin
        pos_r    <= pos_nxt;
        ext_r    <= ext_nxt;
        rem_r    <= rem_nxt;
        id_r     <= id_nxt;
        dcount_r <= dcount_nxt;
        data_r   <= data_nxt;
        hi_r     <= last_r ? 8'd0 : hi_nxt;
      end
      if (proc && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      char_r <= in_tdata;
      last_r <= in_tlast;
    end
    if (proc && last_r) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ASCII CAN frame line parser. Lines of
// characters stream in with random gaps on both sides. Each accepted
// character advances a local line decoder. Each line end queues the expected
// frame, which is compared field by field with the next result transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import acfp_pkg::*;

  localparam int CHAR_TARGET  = 1300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    bit        ok;
    bit        ext;
    bit        rtr;
    bit [31:0] id;
    bit [3:0]  dlc;
    bit [63:0] payload;
  } frame_t;

  class frame_scoreboard;
    bit [4:0]  line_pos;
    bit        ext_line;
    bit        rtr_line;
    bit [31:0] id_acc;
    bit [7:0]  dlc_raw;
    bit [63:0] payload_acc;
    bit [7:0]  hi_digit;
    frame_t    frames_due[$];
    int        mismatches;

    function void clear_line();
      line_pos    = '0;
      ext_line    = 1'b0;
      rtr_line    = 1'b0;
      id_acc      = '0;
      dlc_raw     = '0;
      payload_acc = '0;
      hi_digit    = '0;
    endfunction

    function new();
      mismatches = 0;
      clear_line();
    endfunction

    function bit [7:0] nibble_of(bit [7:0] ch);
      if (ch >= CHAR_LOWER_A) return ch - CHAR_LOWER_A + 8'd10;
      if (ch >= CHAR_UPPER_A) return ch - CHAR_UPPER_A + 8'd10;
      return ch - CHAR_ZERO;
    endfunction

    function bit [7:0] byte_of(bit [7:0] hi, bit [7:0] lo);
      bit [7:0] b;
      b = (hi << 4) | lo;
      return b;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // Advance the line decoder by one accepted character.
    function void note_input(bit [7:0] ch, bit last);
      bit [7:0] nib;
      int       p;
      int       len_pos;
      int       off;
      int       total;
      bit       good;
      frame_t   f;
      p   = line_pos;
      nib = nibble_of(ch);
      if (p == 0) begin
        ext_line = (ch == CHAR_UPPER_R) || (ch == CHAR_UPPER_T);
        rtr_line = (ch == CHAR_LOWER_R) || (ch == CHAR_UPPER_R);
      end
      len_pos = ext_line ? int'(DPOS_EXT) : int'(DPOS_STD);
      if (p > 0 && p < len_pos) begin
        if (ext_line) begin
          if (p % 2 == 1) hi_digit = nib;
          else id_acc = {id_acc[23:0], byte_of(hi_digit, nib)};
        end else if (p == 1) begin
          id_acc = {16'h0000, nib, 8'h00};
        end else if (p == 2) begin
          hi_digit = nib;
        end else begin
          id_acc = (id_acc | {24'h0, byte_of(hi_digit, nib)}) & 32'h0000_FFFF;
        end
      end else if (p == len_pos) begin
        dlc_raw = ch - CHAR_ZERO;
      end else if (p > len_pos) begin
        off = p - len_pos - 1;
        if (off % 2 == 0) hi_digit = nib;
        else if (off / 2 < MAX_DATA_BYTES)
          payload_acc = payload_acc | (64'(byte_of(hi_digit, nib)) << (8 * (off / 2)));
      end
      if (line_pos != POS_MAX) line_pos = line_pos + 5'd1;
      if (!last) return;

      total = p + 1;
      good  = 1'b1;
      if (total < len_pos + 1) good = 1'b0;
      else if (int'(dlc_raw) > MAX_DATA_BYTES) good = 1'b0;
      else if (rtr_line && total != len_pos + 1) good = 1'b0;
      else if (!rtr_line && total != 2 * int'(dlc_raw) + len_pos + 1) good = 1'b0;

      f = '{ok: 1'b0, ext: 1'b0, rtr: 1'b0, id: '0, dlc: '0, payload: '0};
      if (good) begin
        f.ok      = 1'b1;
        f.ext     = ext_line;
        f.rtr     = rtr_line;
        f.id      = id_acc;
        f.dlc     = dlc_raw[3:0];
        f.payload = rtr_line ? 64'h0 : payload_acc;
      end
      frames_due.push_back(f);
      clear_line();
    endfunction

    task report(string msg);
      if (mismatches < 100) $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_result(bit [OUT_DATA_W-1:0] data, bit [OUT_USER_W-1:0] user);
      frame_t f;
      if (frames_due.size() == 0) begin
        report("result transfer with no line end pending");
        return;
      end
      f = frames_due.pop_front();
      if (user[0] != f.ok)
        report($sformatf("ok got %0b want %0b", user[0], f.ok));
      if (user[1] != f.ext)
        report($sformatf("extended got %0b want %0b", user[1], f.ext));
      if (user[2] != f.rtr)
        report($sformatf("remote got %0b want %0b", user[2], f.rtr));
      if (data[31:0] != f.id)
        report($sformatf("identifier got %h want %h", data[31:0], f.id));
      if (data[35:32] != f.dlc)
        report($sformatf("length got %0d want %0d", data[35:32], f.dlc));
      if (data[99:36] != f.payload)
        report($sformatf("payload got %h want %h", data[99:36], f.payload));
      if (data[OUT_DATA_W-1:100] != '0)
        report($sformatf("pad bits got %h", data[OUT_DATA_W-1:100]));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  frame_scoreboard sb = new();
  bit [7:0]        line_q[$];
  bit              tx_free   = 1'b0;
  bit              rx_free   = 1'b0;
  int              chars_out = 0;
  int              idle_cnt  = 0;

  ascii_can_frame_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [7:0] rand_digit();
    string hex;
    hex = "0123456789ABCDEFabcdef";
    if ($urandom_range(0, 99) < 85) return hex[$urandom_range(0, 21)];
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void build_frame();
    bit       ext;
    bit       rtr;
    int       len;
    int       r;
    bit [7:0] first;
    line_q.delete();
    ext = $urandom_range(0, 1);
    rtr = ($urandom_range(0, 3) == 0);
    r   = $urandom_range(0, 9);
    len = (r == 0) ? 0 : (r == 1) ? MAX_DATA_BYTES : $urandom_range(0, MAX_DATA_BYTES);
    if (ext) begin
      first = rtr ? CHAR_UPPER_R : CHAR_UPPER_T;
    end else if (rtr) begin
      first = CHAR_LOWER_R;
    end else if ($urandom_range(0, 3) != 0) begin
      first = "t";
    end else begin
      do first = 8'($urandom_range(1, 255));
      while (first == CHAR_UPPER_R || first == CHAR_UPPER_T || first == CHAR_LOWER_R);
    end
    line_q.push_back(first);
    repeat (ext ? 8 : 3) line_q.push_back(rand_digit());
    line_q.push_back(CHAR_ZERO + 8'(len));
    if (!rtr) repeat (2 * len) line_q.push_back(rand_digit());
  endfunction

  function automatic void build_line();
    int r;
    int n;
    int len_pos;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      build_frame();
    end else if (r < 73) begin
      build_frame();
      len_pos = (line_q[0] == CHAR_UPPER_R || line_q[0] == CHAR_UPPER_T) ? 9 : 4;
      line_q[len_pos] = 8'($urandom_range(1, 255));
    end else if (r < 82) begin
      build_frame();
      n = $urandom_range(1, line_q.size() - 1);
      repeat (n) void'(line_q.pop_back());
    end else if (r < 90) begin
      build_frame();
      repeat ($urandom_range(1, 3)) line_q.push_back(rand_digit());
    end else begin
      // Noise, sometimes long enough to saturate the position counter.
      line_q.delete();
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 40) : $urandom_range(1, 12);
      repeat (n) line_q.push_back(8'($urandom_range(1, 255)));
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_char(input bit [7:0] ch, input bit last);
    int gap;
    gap = tx_free ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = ch;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(ch, last);
    chars_out++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_line();
    tx_free = ($urandom_range(0, 3) == 0);
    foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
  endtask

  // Hold the sender until every pending frame has come out.
  task automatic drain_pause();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int lines;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("r1FF3");        // standard remote
    send_text("RFFFFFFFF0");   // extended remote, top identifier
    send_text("t0009");        // length digit above the limit
    send_text("T");            // line too short
    send_char(8'hFF, 1'b1);
    send_char(8'h01, 1'b1);
    send_text("t12312");       // wrong total length
    drain_pause();

    lines = 0;
    while (chars_out < CHAR_TARGET) begin
      build_line();
      send_line();
      lines++;
      if (lines % 25 == 0) drain_pause();
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, with stretches of steady ready.
  initial begin
    int hold;
    int g;
    hold = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) rx_free = !rx_free;
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else if (rx_free) begin
        out_tready = 1'b1;
      end else begin
        g          = pick_gap();
        out_tready = (g == 0);
        hold       = (g > 0) ? g - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
